// ----- design/tcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_pkg: shared types and constants of the text cell buffer blitter
// Opcodes, controller/datapath command and status structs, default geometry.
// ----------------------------------------------------------------------------
package tcb_pkg;

   localparam int DefaultCols = 80;
   localparam int DefaultRows = 25;

   localparam logic [7:0] SpaceCode = 8'h20;

   typedef enum logic [2:0] {
      OP_PUT    = 3'd0,
      OP_READ   = 3'd1,
      OP_CLRROW = 3'd2,
      OP_CLRALL = 3'd3,
      OP_SCRUP  = 3'd4,
      OP_SCRDN  = 3'd5,
      OP_COPY   = 3'd6,
      OP_FILL   = 3'd7
   } opcode_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, compute rectangle
      logic step_rd;   // issue read of source cell at current position
      logic step_wr;   // write destination cell at current position
      logic advance;   // move to next position
      logic respond;   // drive result strobe
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_read;  // current cell is read from the store first
      logic empty;       // nothing to write
      logic last;        // current position is the final one
   } dp_stat_type;

endpackage

// ----- design/text_cell_buffer_blitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_buffer_blitter: command engine over a text cell store
// Put, read, clear, scroll, copy and fill over a COLS by ROWS cell memory.
// ----------------------------------------------------------------------------
// Put, clear and fill write one cell per step; read and copy pass each cell
//   through read, wait and write states (one memory port). Scroll reads and
//   writes like copy but blanks the freed line, whose first cell still passes
//   through a read. A rejected or empty command goes from setup to the response.
// One transaction at a time; the next is taken in the cycle the result strobes.
// The receiver cannot stall: rsp_valid lasts exactly one cycle per transaction.
// Reset clears the sequencer and strobe; the store is undefined until written.
// ----------------------------------------------------------------------------
module text_cell_buffer_blitter
   import tcb_pkg::*;
#(
   parameter int COLS = DefaultCols,
   parameter int ROWS = DefaultRows
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic        [2:0] req_opcode,
   input  logic signed [8:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic signed [8:0] req_dest_x,
   input  logic signed [8:0] req_dest_y,
   input  logic signed [8:0] req_region_width,
   input  logic signed [8:0] req_region_height,
   input  logic        [7:0] req_cell_char,
   input  logic        [7:0] req_cell_attr,
   input  logic              req_keep_attr,
   output logic              rsp_valid,
   output logic        [7:0] rsp_read_char,
   output logic        [7:0] rsp_read_attr,
   output logic              rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: accept a transaction while idle, walk cells, answer once
   tcb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // datapath: bounds, rectangle walk and the cell memory
   tcb_dp #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_dest_x        (req_dest_x),
      .req_dest_y        (req_dest_y),
      .req_region_width  (req_region_width),
      .req_region_height (req_region_height),
      .req_cell_char     (req_cell_char),
      .req_cell_attr     (req_cell_attr),
      .req_keep_attr     (req_keep_attr),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_attr     (rsp_read_attr),
      .rsp_status        (rsp_status),
      .rsp_valid         (rsp_valid)
   );

endmodule

// ----- design/tcb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_ctrl: command sequencer
// One-hot state machine stepping the datapath through an item's cells.
// ----------------------------------------------------------------------------
module tcb_ctrl
   import tcb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_READ  = 6'b000100,
      ST_WAIT  = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (stat.empty) begin
               state_in = ST_RESP;
            end else if (stat.needs_read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_READ: begin
            cmd.step_rd = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.step_wr = 1'b1;
            if (stat.last) begin
               state_in = ST_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in    = stat.needs_read ? ST_READ : ST_WRITE;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- design/tcb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_dp: cell store and rectangle walker
// Holds the cell memory, the rectangle bounds and the row/column counters.
// ----------------------------------------------------------------------------
module tcb_dp
   import tcb_pkg::*;
#(
   parameter int COLS = DefaultCols,
   parameter int ROWS = DefaultRows
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic        [2:0] req_opcode,
   input  logic signed [8:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic signed [8:0] req_dest_x,
   input  logic signed [8:0] req_dest_y,
   input  logic signed [8:0] req_region_width,
   input  logic signed [8:0] req_region_height,
   input  logic        [7:0] req_cell_char,
   input  logic        [7:0] req_cell_attr,
   input  logic              req_keep_attr,
   output logic        [7:0] rsp_read_char,
   output logic        [7:0] rsp_read_attr,
   output logic              rsp_status,
   output logic              rsp_valid
);

   localparam int Depth = COLS * ROWS;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);

   localparam logic signed [10:0] ColsS = 11'(COLS);
   localparam logic signed [10:0] RowsS = 11'(ROWS);

   logic [15:0] mem [Depth];
   logic [15:0] rdata_ff;

   // captured request
   opcode_type   op_ff;
   logic [7:0]   ch_ff, attr_ff;
   logic         keep_ff;
   logic         bad_ff, empty_ff, rd_ff, rev_ff;
   logic [CW-1:0] x0_ff, sx0_ff;          // destination column start, source start
   logic [RW-1:0] y0_ff, sy0_ff;
   logic [CW-1:0] cx_ff, cx_in;           // column offset in the walk
   logic [RW-1:0] cy_ff, cy_in;
   logic [CW-1:0] wlast_ff;               // width - 1
   logic [RW-1:0] hlast_ff;

   // extended operands
   logic signed [10:0] px, py, dx, dy, w, h, fx, fy, fw, fh, fx1, fy1;
   logic               in_pt, in_row, copy_ok;
   logic [CW-1:0] nx0, nx1, nsx0;
   logic [RW-1:0] ny0, ny1, nsy0;
   logic          n_empty, n_bad, n_rd, n_rev;

   always_comb begin
      px = 11'(req_pos_x);
      py = 11'(req_pos_y);
      dx = 11'(req_dest_x);
      dy = 11'(req_dest_y);
      w  = 11'(req_region_width);
      h  = 11'(req_region_height);
      in_row = (py >= 0) && (py < RowsS);
      in_pt  = in_row && (px >= 0) && (px < ColsS);
      copy_ok = (px >= 0) && (py >= 0) && (dx >= 0) && (dy >= 0) && (w > 0) && (h > 0)
                && (px + w <= ColsS) && (dx + w <= ColsS)
                && (py + h <= RowsS) && (dy + h <= RowsS);
      fx = px; fw = w; fy = py; fh = h;
      if (px < 0) begin
         fw = w + px;
         fx = '0;
      end
      if (py < 0) begin
         fh = h + py;
         fy = '0;
      end
      fx1 = (fx + fw > ColsS) ? ColsS - 11'sd1 : fx + fw - 11'sd1;
      fy1 = (fy + fh > RowsS) ? RowsS - 11'sd1 : fy + fh - 11'sd1;

      nx0 = '0; nx1 = CW'(COLS - 1); ny0 = '0; ny1 = RW'(ROWS - 1);
      nsx0 = '0; nsy0 = '0;
      n_empty = 1'b0; n_bad = 1'b0; n_rd = 1'b0; n_rev = 1'b0;
      unique case (opcode_type'(req_opcode))
         OP_PUT, OP_READ: begin
            nx0 = px[CW-1:0]; nx1 = px[CW-1:0];
            ny0 = py[RW-1:0]; ny1 = py[RW-1:0];
            nsx0 = px[CW-1:0]; nsy0 = py[RW-1:0];
            n_bad   = !in_pt;
            n_empty = !in_pt;
            n_rd    = (opcode_type'(req_opcode) == OP_READ);
         end
         OP_CLRROW: begin
            ny0 = py[RW-1:0]; ny1 = py[RW-1:0];
            n_bad = !in_row; n_empty = !in_row;
         end
         OP_CLRALL: ;
         OP_SCRUP: begin
            n_rd = 1'b1; nsy0 = RW'(1);
         end
         OP_SCRDN: begin
            n_rd = 1'b1; n_rev = 1'b1;
         end
         OP_COPY: begin
            nx0 = dx[CW-1:0]; nx1 = CW'(dx + w - 11'sd1);
            ny0 = dy[RW-1:0]; ny1 = RW'(dy + h - 11'sd1);
            nsx0 = px[CW-1:0]; nsy0 = py[RW-1:0];
            n_bad = !copy_ok; n_empty = !copy_ok; n_rd = 1'b1;
            n_rev = !((dy < py) || ((dy == py) && (dx < px)));
         end
         OP_FILL: begin
            n_empty = !((fx < ColsS) && (fy < RowsS) && (fw > 0) && (fh > 0));
            nx0 = fx[CW-1:0]; nx1 = fx1[CW-1:0];
            ny0 = fy[RW-1:0]; ny1 = fy1[RW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= opcode_type'(req_opcode);
         ch_ff    <= req_cell_char;
         attr_ff  <= req_cell_attr;
         keep_ff  <= req_keep_attr;
         bad_ff   <= n_bad;
         empty_ff <= n_empty;
         rd_ff    <= n_rd;
         rev_ff   <= n_rev;
         x0_ff    <= nx0;
         y0_ff    <= ny0;
         sx0_ff   <= nsx0;
         sy0_ff   <= nsy0;
         wlast_ff <= nx1 - nx0;
         hlast_ff <= ny1 - ny0;
      end
   end

   // walk offsets: forward from 0, reverse from the far corner
   logic at_end_x, at_end_y;
   assign at_end_x = rev_ff ? (cx_ff == '0) : (cx_ff == wlast_ff);
   assign at_end_y = rev_ff ? (cy_ff == '0) : (cy_ff == hlast_ff);

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (cmd.load) begin
         cx_in = n_rev ? nx1 - nx0 : '0;
         cy_in = n_rev ? ny1 - ny0 : '0;
      end else if (cmd.advance) begin
         if (at_end_x) begin
            cx_in = rev_ff ? wlast_ff : '0;
            cy_in = rev_ff ? cy_ff - RW'(1) : cy_ff + RW'(1);
         end else begin
            cx_in = rev_ff ? cx_ff - CW'(1) : cx_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
   end

   // addresses; scroll up writes rows 0..ROWS-2 from below, down rows ROWS-1..1
   logic [RW-1:0] wrow, srow;
   logic [CW-1:0] wcol, scol;
   logic          last_row_blank;
   logic [AW-1:0] waddr, raddr;

   always_comb begin
      wrow = y0_ff + cy_ff;
      wcol = x0_ff + cx_ff;
      srow = sy0_ff + cy_ff;
      scol = sx0_ff + cx_ff;
      if (op_ff == OP_SCRDN) begin
         srow = cy_ff - RW'(1);
      end
      last_row_blank = ((op_ff == OP_SCRUP) && (cy_ff == RW'(ROWS - 1)))
                    || ((op_ff == OP_SCRDN) && (cy_ff == '0));
      waddr = AW'(wrow) * AW'(COLS) + AW'(wcol);
      raddr = AW'(srow) * AW'(COLS) + AW'(scol);
   end

   logic [15:0] wdata;
   always_comb begin
      unique case (op_ff)
         OP_PUT, OP_FILL: wdata = {attr_ff, ch_ff};
         OP_SCRUP, OP_SCRDN: begin
            if (last_row_blank) begin
               wdata = {attr_ff, SpaceCode};
            end else if (keep_ff) begin
               wdata = rdata_ff;
            end else begin
               wdata = {attr_ff, rdata_ff[7:0]};
            end
         end
         OP_COPY: wdata = rdata_ff;
         default: wdata = {attr_ff, SpaceCode};
      endcase
   end

   logic do_wr;
   assign do_wr = cmd.step_wr && (op_ff != OP_READ);

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[waddr] <= wdata;
      end
      if (cmd.step_rd) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      stat.needs_read = rd_ff && !last_row_blank;
      stat.empty      = empty_ff;
      stat.last       = at_end_x && at_end_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_status    <= bad_ff;
         rsp_read_char <= (op_ff == OP_READ && !bad_ff) ? rdata_ff[7:0] : 8'h00;
         rsp_read_attr <= (op_ff == OP_READ && !bad_ff) ? rdata_ff[15:8] : 8'h00;
      end
   end

endmodule
